FILE: hdl/baro_temp_pressure_compensator_unit_defines.svh
// assertion macros for the compensator checker
`ifndef BARO_TEMP_PRESSURE_COMPENSATOR_UNIT_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATOR_UNIT_DEFINES_SVH
// implication check under reset
`define BTPC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("check failed");
// next-cycle check under reset
`define BTPC_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("check failed");
`endif

FILE: hdl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// shared types, constants and a helper function of the pressure and temperature compensator
// ----------------------------------------------------------------------------
package btpc_pkg;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OSS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AC12 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AC34 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AC56 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B12 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MCMD = 3'd5;
   localparam logic KIND_TEMP = 1'b0;
   localparam logic KIND_PRES = 1'b1;

   // datapath micro operations
   typedef enum logic [4:0] {
      OP_NONE, OP_T0, OP_T1, OP_T2, OP_TDIV, OP_T3,
      OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7, OP_P8,
      OP_PDIV, OP_P9, OP_P10, OP_P11, OP_P12, OP_P13
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_T0, ST_T1, ST_T2, ST_TDIV, ST_TWAIT, ST_T3,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
      ST_PDIV, ST_PWAIT, ST_P9, ST_P10, ST_P11, ST_P12, ST_P13, ST_OUT
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic div_zero;
   } sts_type;

   // signed divide by 2^k truncating toward zero
   function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
      logic [31:0] bias;
      bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return 32'($signed(a + bias) >>> k);
   endfunction
endpackage

FILE: hdl/btpc_divider.sv
// ----------------------------------------------------------------------------
// btpc_divider
// unsigned 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module btpc_divider import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   // start load, or one shift and subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         rem_in = '0; quo_in = dividend; cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0]; quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]}; quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) dvs_ff <= divisor;
      rem_ff <= rem_in; quo_ff <= quo_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: hdl/btpc_datapath.sv
// ----------------------------------------------------------------------------
// btpc_datapath
// coefficient registers, working registers, one multiplier and the divider
// ----------------------------------------------------------------------------
module btpc_datapath import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0] csr_data,
   input  logic        load,
   input  logic        in_kind,
   input  logic [15:0] in_word,
   input  logic [7:0]  in_xbyte,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [31:0] value,
   output logic        zero_flag,
   output logic        kind
);
   logic [1:0]  oss_ff;
   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff, b5_ff;
   logic [31:0] r_x1_ff, r_b6_ff, r_sq_ff, r_b3_ff, r_acc_ff, r_p_ff, r_t_ff, r_up_ff;
   logic [15:0] word_ff;
   logic [7:0]  xb_ff;
   logic        kind_ff, zero_ff, neg_ff;
   logic [31:0] ma, mb, prod;
   logic        dstart;
   logic [31:0] dnum, dden, dq;
   logic        ddone;
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

   assign ac1 = {{16{ac12_ff[31]}}, ac12_ff[31:16]};
   assign ac2 = {{16{ac12_ff[15]}}, ac12_ff[15:0]};
   assign ac3 = {{16{ac34_ff[31]}}, ac34_ff[31:16]};
   assign ac4 = {16'd0, ac34_ff[15:0]};
   assign ac5 = {16'd0, ac56_ff[31:16]};
   assign ac6 = {16'd0, ac56_ff[15:0]};
   assign b1  = {{16{b12_ff[31]}}, b12_ff[31:16]};
   assign b2  = {{16{b12_ff[15]}}, b12_ff[15:0]};
   assign mc  = {{16{mcmd_ff[31]}}, mcmd_ff[31:16]};
   assign md  = {{16{mcmd_ff[15]}}, mcmd_ff[15:0]};

   // shared multiplier operand select
   always_comb begin
      ma = '0; mb = '0;
      case (cmd.op)
         OP_T0:  begin ma = {16'd0, word_ff} - ac6; mb = ac5; end
         OP_P1:  begin ma = r_b6_ff; mb = r_b6_ff; end
         OP_P2:  begin ma = b2; mb = r_sq_ff; end
         OP_P3:  begin ma = ac2; mb = r_b6_ff; end
         OP_P5:  begin ma = ac3; mb = r_b6_ff; end
         OP_P6:  begin ma = b1; mb = r_sq_ff; end
         OP_P7:  begin ma = ac4; mb = r_acc_ff + 32'd32768; end
         OP_P8:  begin ma = r_up_ff - r_b3_ff; mb = 32'd50000 >> oss_ff; end
         OP_P10: begin ma = r_t_ff; mb = r_t_ff; end
         OP_P11: begin ma = r_t_ff; mb = 32'd3038; end
         OP_P12: begin ma = 32'd0 - 32'd7357; mb = r_p_ff; end
         default: ;
      endcase
      prod = 32'(ma * mb);
   end

   // divider launch
   always_comb begin
      dstart = 1'b0; dnum = '0; dden = '0;
      case (cmd.op)
         OP_TDIV: begin
            dstart = 1'b1;
            dnum = r_t_ff[31] ? 32'd0 - r_t_ff : r_t_ff;
            dden = r_acc_ff[31] ? 32'd0 - r_acc_ff : r_acc_ff;
         end
         OP_PDIV: begin
            dstart = 1'b1;
            dnum = r_acc_ff[31] ? r_acc_ff : {r_acc_ff[30:0], 1'b0};
            dden = r_x1_ff;
         end
         default: ;
      endcase
   end

   btpc_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dnum),
      .divisor(dden), .done(ddone), .quotient(dq)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff <= '0; ac12_ff <= '0; ac34_ff <= '0; ac56_ff <= '0;
         b12_ff <= '0; mcmd_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_OSS:  oss_ff <= csr_data[1:0];
            REG_AC12: ac12_ff <= csr_data;
            REG_AC34: ac34_ff <= csr_data;
            REG_AC56: ac56_ff <= csr_data;
            REG_B12:  b12_ff <= csr_data;
            REG_MCMD: mcmd_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // working registers step by step
   always_ff @(posedge clock) begin
      if (reset) begin
         b5_ff <= '0;
      end else begin
         if (load) begin
            word_ff <= in_word; xb_ff <= in_xbyte; kind_ff <= in_kind; zero_ff <= 1'b0;
         end
         case (cmd.op)
            OP_T0: r_x1_ff <= sdiv_pow2(prod, 5'd15);
            OP_T1: begin
               r_acc_ff <= r_x1_ff + md;
               r_t_ff <= mc << 11;
            end
            OP_T2: begin
               zero_ff <= (r_acc_ff == 32'd0);
               neg_ff <= r_t_ff[31] ^ r_acc_ff[31];
            end
            OP_T3: begin
               if (!zero_ff) begin
                  b5_ff <= r_x1_ff + (neg_ff ? 32'd0 - dq : dq);
                  r_p_ff <= sdiv_pow2(r_x1_ff + (neg_ff ? 32'd0 - dq : dq) + 32'd8, 5'd4);
               end else r_p_ff <= '0;
            end
            OP_P0: begin
               r_b6_ff <= b5_ff - 32'd4000;
               r_up_ff <= ({16'd0, word_ff} << 8 | {24'd0, xb_ff}) >> (4'd8 - {2'd0, oss_ff});
            end
            OP_P1: r_sq_ff <= sdiv_pow2(prod, 5'd12);
            OP_P2: r_acc_ff <= sdiv_pow2(prod, 5'd11);
            OP_P3: r_b3_ff <= sdiv_pow2((((ac1 << 2) + r_acc_ff + sdiv_pow2(prod, 5'd11))
                                        << oss_ff) + 32'd2, 5'd2);
            OP_P5: r_acc_ff <= sdiv_pow2(prod, 5'd13);
            OP_P6: r_acc_ff <= sdiv_pow2(r_acc_ff + sdiv_pow2(prod, 5'd16) + 32'd2, 5'd2);
            OP_P7: begin
               r_x1_ff <= prod >> 15;
               zero_ff <= ((prod >> 15) == 32'd0);
            end
            OP_P8: r_acc_ff <= prod;
            OP_P9: begin
               r_p_ff <= r_acc_ff[31] ? {dq[30:0], 1'b0} : dq;
               r_t_ff <= sdiv_pow2(r_acc_ff[31] ? {dq[30:0], 1'b0} : dq, 5'd8);
            end
            OP_P10: r_t_ff <= prod;
            OP_P11: r_t_ff <= sdiv_pow2(prod, 5'd16);
            OP_P12: r_t_ff <= r_t_ff + sdiv_pow2(prod, 5'd16) + 32'd3791;
            OP_P13: r_p_ff <= zero_ff ? 32'd0 : r_p_ff + sdiv_pow2(r_t_ff, 5'd4);
            default: ;
         endcase
      end
   end

   assign sts.div_done = ddone;
   assign sts.div_zero = zero_ff;
   assign value = r_p_ff;
   assign zero_flag = zero_ff;
   assign kind = kind_ff;
endmodule

FILE: hdl/btpc_controller.sv
// ----------------------------------------------------------------------------
// btpc_controller
// sequencer for temperature and pressure compensation steps
// ----------------------------------------------------------------------------
module btpc_controller import btpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    start_kind,
   input  logic    out_taken,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    idle,
   output logic    out_valid
);
   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = (start_kind == KIND_PRES) ? ST_P0 : ST_T0;
         ST_T0:    state_in = ST_T1;
         ST_T1:    state_in = ST_T2;
         ST_T2:    state_in = ST_TDIV;
         ST_TDIV:  state_in = sts.div_zero ? ST_T3 : ST_TWAIT;
         ST_TWAIT: if (sts.div_done) state_in = ST_T3;
         ST_T3:    state_in = ST_OUT;
         ST_P0:    state_in = ST_P1;
         ST_P1:    state_in = ST_P2;
         ST_P2:    state_in = ST_P3;
         ST_P3:    state_in = ST_P4;
         ST_P4:    state_in = ST_P5;
         ST_P5:    state_in = ST_P6;
         ST_P6:    state_in = ST_P7;
         ST_P7:    state_in = ST_P8;
         ST_P8:    state_in = sts.div_zero ? ST_P13 : ST_PDIV;
         ST_PDIV:  state_in = ST_PWAIT;
         ST_PWAIT: if (sts.div_done) state_in = ST_P9;
         ST_P9:    state_in = ST_P10;
         ST_P10:   state_in = ST_P11;
         ST_P11:   state_in = ST_P12;
         ST_P12:   state_in = ST_P13;
         ST_P13:   state_in = ST_OUT;
         ST_OUT:   if (out_taken) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         ST_T0:   cmd.op = OP_T0;
         ST_T1:   cmd.op = OP_T1;
         ST_T2:   cmd.op = OP_T2;
         ST_TDIV: cmd.op = sts.div_zero ? OP_NONE : OP_TDIV;
         ST_T3:   cmd.op = OP_T3;
         ST_P0:   cmd.op = OP_P0;
         ST_P1:   cmd.op = OP_P1;
         ST_P2:   cmd.op = OP_P2;
         ST_P3:   cmd.op = OP_P3;
         ST_P5:   cmd.op = OP_P5;
         ST_P6:   cmd.op = OP_P6;
         ST_P7:   cmd.op = OP_P7;
         ST_P8:   cmd.op = OP_P8;
         ST_PDIV: cmd.op = OP_PDIV;
         ST_P9:   cmd.op = OP_P9;
         ST_P10:  cmd.op = OP_P10;
         ST_P11:  cmd.op = OP_P11;
         ST_P12:  cmd.op = OP_P12;
         ST_P13:  cmd.op = OP_P13;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign idle = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
endmodule

FILE: hdl/baro_temp_pressure_compensator_unit.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensator_unit
// barometric temperature and pressure compensation with calibration registers
// ----------------------------------------------------------------------------
// channel  direction  contents
// req_     in         tuser type, tdata {extra byte, raw word}
// rsp_     out        tuser {status, kind}, tdata value
// csr_     in         index and 32-bit write data
// a temperature or pressure item runs the serial divider at most once, skipping it
// when the divisor is zero, so each item uses at most one division.
// one item at a time; req_tready is high only when the sequencer is idle.
// the result holds in rsp_tdata until rsp_tready takes it.
// reset is synchronous and clears coefficients and the stored b5 term.
module baro_temp_pressure_compensator_unit import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // raw_word[15:0], raw_extra_byte[23:16]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // comp_value[31:0]
   output logic [1:0]  rsp_tuser,   // result_kind[0], status[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0] csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic    idle, load, zero_flag, kind;
   logic [31:0] value;

   assign load = req_tvalid & idle;
   assign req_tready = idle;
   assign csr_ready = 1'b1;

   btpc_controller u_ctrl (
      .clock(clock), .reset(reset), .start(load), .start_kind(req_tuser),
      .out_taken(rsp_tready), .sts(sts), .cmd(cmd), .idle(idle), .out_valid(rsp_tvalid)
   );

   btpc_datapath u_dp (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_index(csr_index),
      .csr_data(csr_data), .load(load), .in_kind(req_tuser), .in_word(req_tdata[15:0]),
      .in_xbyte(req_tdata[23:16]), .cmd(cmd), .sts(sts), .value(value),
      .zero_flag(zero_flag), .kind(kind)
   );

   assign rsp_tdata = value;
   assign rsp_tuser = {zero_flag, kind};
endmodule

FILE: hdl/btpc_checker.sv
// ----------------------------------------------------------------------------
// btpc_checker
// port-level checks of the compensator
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensator_unit_defines.svh"
module btpc_checker import btpc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   // a failed division always reports zero
   `BTPC_ASSERT_IMP(a_zero_value, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata == 32'd0)
   // no input taken while a result waits
   `BTPC_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   // a transfer in leaves the block busy
   `BTPC_ASSERT_NXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // a stalled result holds
   `BTPC_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
endmodule

bind baro_temp_pressure_compensator_unit btpc_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
